// File: hw/rtl/tcgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared types and constants for the glyph renderer modules.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CODE_W  = 8;
    localparam int LINE_W  = 4;
    localparam int FADDR_W = CODE_W + LINE_W;
    localparam int COLOR_W = 24;
    localparam int CFG_IDX_W = 2;

    // Operation codes of an input item.
    localparam logic [1:0] OP_PRINT  = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_FONT   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAPER  = 2'd2;

    localparam logic [COLOR_W-1:0] INK_RESET    = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] CURSOR_RESET = 24'h808080;
    localparam logic [COLOR_W-1:0] PAPER_RESET  = 24'h000000;

    // Character codes with special handling.
    localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
    localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CODE_W-1:0] CH_BAR   = 8'h7C;

    localparam logic [LINE_W-1:0] LINE_LAST = 4'd15;
    localparam logic [8:0] TAB_STEP = 9'd4;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CODE_W-1:0] char_code;
        logic [LINE_W-1:0] glyph_line;
        logic [7:0]        font_bits;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         pixel_x;
        logic [8:0]         pixel_y;
        logic [7:0]         pattern;
        logic [COLOR_W-1:0] ink_color;
        logic [COLOR_W-1:0] paper_color;
        logic               last;
    } t_out_item;

    // Everything of a result row except the font pattern.
    typedef struct packed {
        logic [9:0]         pixel_x;
        logic [8:0]         pixel_y;
        logic [COLOR_W-1:0] ink_color;
        logic [COLOR_W-1:0] paper_color;
        logic               last;
    } t_row_tag;

    typedef struct packed {
        logic               en;
        logic [FADDR_W-1:0] addr;
    } t_font_rd;

    typedef struct packed {
        logic               en;
        logic [FADDR_W-1:0] addr;
        logic [7:0]         data;
    } t_font_wr;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COLOR_W-1:0] ink;
    } t_cell;

endpackage

// File: hw/rtl/tcgr_font_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph font memory
// 256 glyphs by 16 lines of 8 bits, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcgr_font_mem (
    input  logic              i_clk,
    input  tcgr_pkg::t_font_wr i_wr,
    input  tcgr_pkg::t_font_rd i_rd,
    output logic [7:0]        o_rd_data
);
    import tcgr_pkg::*;

    logic [7:0] r_font [0:(1 << FADDR_W) - 1];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_font[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_font[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/tcgr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph renderer control
// Holds the cursor and colors, passes font writes on, plans the cells of an
// item and issues one font read per glyph row.
// ----------------------------------------------------------------------------
module tcgr_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 30
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tcgr_pkg::COLOR_W-1:0]          i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  tcgr_pkg::t_in_item                    i_in_data,
    input  logic                                  i_issue_ok,
    output tcgr_pkg::t_font_rd                    o_rd,
    output tcgr_pkg::t_font_wr                    o_wr,
    output tcgr_pkg::t_row_tag                    o_tag
);
    import tcgr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam logic [7:0] COLS_1   = 8'(COLUMNS);
    localparam logic [8:0] COLS_9   = 9'(COLUMNS);
    localparam logic [8:0] COLS2_9  = 9'(2 * COLUMNS);
    localparam logic [5:0] ROWS_6   = 6'(ROWS);
    localparam logic [5:0] ROW_MAX  = 6'(ROWS - 1);

    logic               r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_shown, n_shown;
    logic [COLOR_W-1:0] r_ink, r_cursor, r_paper;
    t_cell              r_cell0, n_cell0, r_cell1, n_cell1;
    logic               r_two, n_two;
    logic               r_sel, n_sel;
    logic [LINE_W-1:0]  r_line, n_line;

    logic               accept;
    logic [5:0]         row_step;
    logic [7:0]         col_inc;
    logic [8:0]         tab_sum;
    t_cell              cur;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state == ST_EMIT);
    assign cur        = r_sel ? r_cell1 : r_cell0;

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_shown  = r_shown;
        n_cell0  = r_cell0;
        n_cell1  = r_cell1;
        n_two    = r_two;
        n_sel    = r_sel;
        n_line   = r_line;
        row_step = {1'b0, r_row};
        col_inc  = {1'b0, r_col} + 8'd1;
        tab_sum  = {2'b0, r_col} + TAB_STEP;

        o_wr.en   = accept && (i_in_data.operation == OP_FONT);
        o_wr.addr = {i_in_data.char_code, i_in_data.glyph_line};
        o_wr.data = i_in_data.font_bits;

        o_rd.en   = (r_state == ST_EMIT) && i_issue_ok;
        o_rd.addr = {cur.code, r_line};

        o_tag.pixel_x     = {cur.col, 3'b000};
        o_tag.pixel_y     = {cur.row, r_line};
        o_tag.ink_color   = cur.ink;
        o_tag.paper_color = r_paper;
        o_tag.last        = (r_line == LINE_LAST) && (r_sel == r_two);

        if (accept) begin
            n_sel   = 1'b0;
            n_line  = '0;
            n_two   = 1'b0;
            n_cell0 = '{code: CH_SPACE, col: r_col, row: r_row, ink: r_ink};
            n_cell1 = '{code: CH_SPACE, col: r_col, row: r_row, ink: r_ink};
            unique case (i_in_data.operation)
                OP_TOGGLE: begin
                    n_state = ST_EMIT;
                    n_shown = !r_shown;
                    if (!r_shown) begin
                        n_cell0.code = CH_BAR;
                        n_cell0.ink  = r_cursor;
                    end
                end
                OP_PRINT: begin
                    n_state = ST_EMIT;
                    case (i_in_data.char_code)
                        CH_BS: begin
                            if (r_col != '0) begin
                                n_two       = 1'b1;
                                n_col       = r_col - 7'd1;
                                n_cell1.col = r_col - 7'd1;
                            end
                        end
                        CH_NL: begin
                            row_step = {1'b0, r_row} + 6'd1;
                            n_col    = '0;
                        end
                        CH_CR: begin
                            n_col = '0;
                        end
                        CH_TAB: begin
                            // Tiny column counts can wrap a tab across two rows.
                            if (tab_sum >= COLS2_9) begin
                                n_col    = 7'(tab_sum - COLS2_9);
                                row_step = {1'b0, r_row} + 6'd2;
                            end else if (tab_sum >= COLS_9) begin
                                n_col    = 7'(tab_sum - COLS_9);
                                row_step = {1'b0, r_row} + 6'd1;
                            end else begin
                                n_col = 7'(tab_sum);
                            end
                        end
                        default: begin
                            n_two        = 1'b1;
                            n_cell1.code = i_in_data.char_code;
                            if (col_inc == COLS_1) begin
                                n_col    = '0;
                                row_step = {1'b0, r_row} + 6'd1;
                            end else begin
                                n_col = 7'(col_inc);
                            end
                        end
                    endcase
                    // The bottom row clamps; there is no scrolling.
                    if (row_step >= ROWS_6) begin
                        n_row = 5'(ROW_MAX);
                    end else begin
                        n_row = 5'(row_step);
                    end
                end
                default: begin
                end
            endcase
        end

        if (o_rd.en) begin
            n_line = r_line + 4'd1;
            if (r_line == LINE_LAST) begin
                if (r_sel == r_two) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sel = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_shown  <= 1'b0;
            r_two    <= 1'b0;
            r_sel    <= 1'b0;
            r_line   <= '0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_row    <= n_row;
            r_shown  <= n_shown;
            r_two    <= n_two;
            r_sel    <= n_sel;
            r_line   <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell0 <= n_cell0;
        r_cell1 <= n_cell1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ink    <= INK_RESET;
            r_cursor <= CURSOR_RESET;
            r_paper  <= PAPER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INK:    r_ink    <= i_cfg_data;
                REG_CURSOR: r_cursor <= i_cfg_data;
                REG_PAPER:  r_paper  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/tcgr_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry queue between the font read stage and the result channel.
// ----------------------------------------------------------------------------
module tcgr_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tcgr_pkg::t_out_item  i_data,
    input  logic                 i_pop,
    output logic                 o_valid,
    output tcgr_pkg::t_out_item  o_data,
    output logic [1:0]           o_count
);
    import tcgr_pkg::*;

    t_out_item  r_entry [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: hw/rtl/text_console_glyph_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Keeps a cursor and an 8x16 font memory, takes print, cursor toggle and font
// write items and makes glyph rows of prints and toggles for a pixel plotter.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ---------------------------
//  in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// A font write does not stall the input channel. A toggle or a print of a control
// character occupies the block for the accepting cycle and 16 font reads, and
// a print of a glyph or a backspace away from column zero for the accepting
// cycle and 32 font reads: the font memory delivers one glyph row per cycle,
// while the result side does not stall, through its single read port. Reset
// clears the cursor and the visible flag and returns the colors to their reset
// values; the font memory holds garbage until written. A stall on the result
// side holds back font reads once the two-entry result buffer would fill.
//
// Each transfer on the input channel is handled whole before the next one is
// taken: o_in_stall stays high while the rows of the planned cells are read.
// The cursor moves at the input transfer, so the cell plan is fixed from then
// on. Font reads are tagged with position and colors; the tag is registered
// beside the memory's read data so both reach the result buffer together.
// A read is issued only when the buffer plus the read in flight leave room,
// so no row is ever dropped.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 30
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcgr_pkg::COLOR_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tcgr_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tcgr_pkg::t_out_item             o_out_data
);
    import tcgr_pkg::*;

    t_font_rd   rd;
    t_font_wr   wr;
    t_row_tag   tag;
    t_row_tag   r_tag;
    logic       r_rd_valid;
    logic [7:0] rd_data;
    logic       issue_ok;
    logic       out_pop;
    logic [1:0] buf_count;
    t_out_item  push_item;

    assign out_pop = o_out_valid && !i_out_stall;

    // Room check counts the buffered rows and the read still in flight.
    assign issue_ok = ((buf_count + {1'b0, r_rd_valid}) < 2'd2) || out_pop;

    tcgr_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_issue_ok  (issue_ok),
        .o_rd        (rd),
        .o_wr        (wr),
        .o_tag       (tag)
    );

    tcgr_font_mem u_font_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= rd.en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd.en) begin
            r_tag <= tag;
        end
    end

    always_comb begin
        push_item.pixel_x     = r_tag.pixel_x;
        push_item.pixel_y     = r_tag.pixel_y;
        push_item.pattern     = rd_data;
        push_item.ink_color   = r_tag.ink_color;
        push_item.paper_color = r_tag.paper_color;
        push_item.last        = r_tag.last;
    end

    tcgr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_rd_valid),
        .i_data  (push_item),
        .i_pop   (out_pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_count (buf_count)
    );

    // A returning font row always finds room in the result buffer.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (buf_count != 2'd2) || out_pop)
        else $error("result buffer overflow");

    // Font reads are issued only while an item is being worked on.
    a_read_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd.en |-> o_in_stall)
        else $error("font read outside of an item");

    // A font write never coincides with a font read.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> !rd.en)
        else $error("font write during font read");

endmodule
